FILE: rtl/aet_pkg.sv
package aet_pkg;

  localparam int LINE_BITS   = 16;
  localparam int COLUMN_BITS = 16;
  localparam int FIELD_BITS  = 16;
  localparam int MAX_TOKENS  = 3;
  localparam int COUNT_BITS  = $clog2(MAX_TOKENS + 1);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};
  localparam logic [COLUMN_BITS-1:0] COL_MAX  = {COLUMN_BITS{1'b1}};

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_INT   = 2'd1,
    MODE_FLOAT = 2'd2,
    MODE_ERR   = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    KIND_PLUS   = 4'd0,
    KIND_MINUS  = 4'd1,
    KIND_MUL    = 4'd2,
    KIND_DIV    = 4'd3,
    KIND_LPAREN = 4'd4,
    KIND_RPAREN = 4'd5,
    KIND_INT    = 4'd6,
    KIND_FLOAT  = 4'd7,
    KIND_EOL    = 4'd8,
    KIND_EOF    = 4'd9,
    KIND_ERR    = 4'd10
  } kind_t;

  typedef struct packed {
    kind_t                 kind;
    logic [FIELD_BITS-1:0] line;
    logic [FIELD_BITS-1:0] first_col;
    logic [FIELD_BITS-1:0] final_col;
  } token_t;

  // all tokens caused by one text byte
  typedef struct packed {
    token_t [MAX_TOKENS-1:0] tok;
    logic [COUNT_BITS-1:0]   count;
  } bundle_t;

  typedef struct packed {
    logic    push;
    bundle_t data;
  } qwr_t;

endpackage

FILE: rtl/arith_expr_tokenizer.sv
// Streaming lexer for arithmetic expressions.
// Input side is a queue write port: drive in_char_byte and in_end_of_text
// with in_push; a byte transfers on a clock edge with in_push high and
// in_full low. Mark the last byte of a text with in_end_of_text.
// Result side is a queue read port: while out_empty is low the oldest token
// (kind, line, first and final column) is on the out_ ports; it transfers on
// an edge with out_pop high. out_run_end marks the last token of one byte.
// A byte gives zero to three tokens, queued as it transfers and shown after
// older tokens. One byte is taken per cycle while in_full is low; tokens
// leave at one per cycle, so bytes that give several tokens, or a stalled
// reader, fill the four-entry queue (one entry per byte that gives tokens,
// up to three tokens each) between the classifier and the output
// serializer, and in_full then holds the input side.
// Synchronous reset (rst_n low) empties the queue and restores line 1,
// column 1 with no token pending. End of text also restores this state.
module arith_expr_tokenizer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_char_byte,
  input  logic        in_end_of_text,
  input  logic        out_pop,
  output logic        out_empty,
  output logic [3:0]  out_token_kind,
  output logic [15:0] out_token_line,
  output logic [15:0] out_first_column,
  output logic [15:0] out_final_column,
  output logic        out_run_end
);

  aet_pkg::qwr_t    qwr;
  aet_pkg::bundle_t head;
  logic             q_empty;
  logic             q_pop;

  aet_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_push && !in_full),
    .char_byte   (in_char_byte),
    .end_of_text (in_end_of_text),
    .qwr         (qwr)
  );

  aet_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .qwr   (qwr),
    .pop   (q_pop),
    .full  (in_full),
    .empty (q_empty),
    .head  (head)
  );

  aet_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .q_empty          (q_empty),
    .q_pop            (q_pop),
    .out_pop          (out_pop),
    .out_empty        (out_empty),
    .out_token_kind   (out_token_kind),
    .out_token_line   (out_token_line),
    .out_first_column (out_first_column),
    .out_final_column (out_final_column),
    .out_run_end      (out_run_end)
  );

endmodule

FILE: rtl/aet_front.sv
module aet_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic [7:0]           char_byte,
  input  logic                 end_of_text,
  output aet_pkg::qwr_t        qwr
);

  aet_pkg::mode_t                   mode_r, mode_nxt;
  logic [aet_pkg::LINE_BITS-1:0]    line_r, line_nxt;
  logic [aet_pkg::COLUMN_BITS-1:0]  col_r, col_nxt;
  logic [aet_pkg::COLUMN_BITS-1:0]  start_r, start_nxt;
  logic                             pin_r, pin_nxt;

  aet_pkg::mode_t                   w_mode;
  logic [aet_pkg::LINE_BITS-1:0]    w_line;
  logic [aet_pkg::COLUMN_BITS-1:0]  w_col;
  logic [aet_pkg::COLUMN_BITS-1:0]  w_start;
  logic                             w_pin;
  aet_pkg::token_t [aet_pkg::MAX_TOKENS-1:0] w_tok;
  logic [aet_pkg::COUNT_BITS-1:0]   w_cnt;

  function automatic aet_pkg::token_t mk_tok(aet_pkg::kind_t kind,
                                             logic [aet_pkg::LINE_BITS-1:0] ln,
                                             logic [aet_pkg::COLUMN_BITS-1:0] fc,
                                             logic [aet_pkg::COLUMN_BITS-1:0] lc);
    aet_pkg::token_t t;
    t.kind      = kind;
    t.line      = aet_pkg::FIELD_BITS'(ln);
    t.first_col = aet_pkg::FIELD_BITS'(fc);
    t.final_col = aet_pkg::FIELD_BITS'(lc);
    return t;
  endfunction

  function automatic logic [aet_pkg::COLUMN_BITS-1:0] last_col(
      logic [aet_pkg::COLUMN_BITS-1:0] cc, logic pin);
    logic [aet_pkg::COLUMN_BITS-1:0] r;
    if (pin) begin
      r = aet_pkg::COL_MAX;
    end else if (cc > aet_pkg::COLUMN_BITS'(1)) begin
      r = cc - aet_pkg::COLUMN_BITS'(1);
    end else begin
      r = aet_pkg::COLUMN_BITS'(1);
    end
    return r;
  endfunction

  function automatic aet_pkg::kind_t pend_kind(aet_pkg::mode_t m);
    aet_pkg::kind_t k;
    case (m)
      aet_pkg::MODE_INT:   k = aet_pkg::KIND_INT;
      aet_pkg::MODE_FLOAT: k = aet_pkg::KIND_FLOAT;
      default:             k = aet_pkg::KIND_ERR;
    endcase
    return k;
  endfunction

  function automatic aet_pkg::kind_t op_kind(logic [7:0] c);
    aet_pkg::kind_t k;
    case (c)
      aet_pkg::CH_PLUS:   k = aet_pkg::KIND_PLUS;
      aet_pkg::CH_MINUS:  k = aet_pkg::KIND_MINUS;
      aet_pkg::CH_STAR:   k = aet_pkg::KIND_MUL;
      aet_pkg::CH_SLASH:  k = aet_pkg::KIND_DIV;
      aet_pkg::CH_LPAREN: k = aet_pkg::KIND_LPAREN;
      aet_pkg::CH_RPAREN: k = aet_pkg::KIND_RPAREN;
      default:            k = aet_pkg::KIND_ERR;
    endcase
    return k;
  endfunction

  // walk one byte: pending flush, idle classify, end-of-text flush
  always_comb begin
    logic digit;
    logic taken;
    logic at_max;
    digit   = char_byte inside {[aet_pkg::CH_ZERO:aet_pkg::CH_NINE]};
    taken   = 1'b0;
    w_mode  = mode_r;
    w_line  = line_r;
    w_col   = col_r;
    w_start = start_r;
    w_pin   = pin_r;
    w_tok   = '0;
    w_cnt   = '0;

    case (w_mode)
      aet_pkg::MODE_INT: begin
        if (digit || char_byte == aet_pkg::CH_DOT) begin
          if (!digit) begin
            w_mode = aet_pkg::MODE_FLOAT;
          end
          taken = 1'b1;
        end else begin
          w_tok[w_cnt] = mk_tok(aet_pkg::KIND_INT, w_line, w_start, last_col(w_col, w_pin));
          w_cnt  = w_cnt + aet_pkg::COUNT_BITS'(1);
          w_mode = aet_pkg::MODE_IDLE;
        end
      end
      aet_pkg::MODE_FLOAT: begin
        if (digit) begin
          taken = 1'b1;
        end else begin
          w_tok[w_cnt] = mk_tok(aet_pkg::KIND_FLOAT, w_line, w_start,
                                last_col(w_col, w_pin));
          w_cnt  = w_cnt + aet_pkg::COUNT_BITS'(1);
          w_mode = aet_pkg::MODE_IDLE;
        end
      end
      aet_pkg::MODE_ERR: begin
        taken = 1'b1;
      end
      default: begin
      end
    endcase

    if (!taken) begin
      case (char_byte)
        aet_pkg::CH_SPACE: begin
        end
        aet_pkg::CH_NL: begin
          w_tok[w_cnt] = mk_tok(aet_pkg::KIND_EOL, w_line, w_col, w_col);
          w_cnt = w_cnt + aet_pkg::COUNT_BITS'(1);
        end
        aet_pkg::CH_PLUS, aet_pkg::CH_MINUS, aet_pkg::CH_STAR,
        aet_pkg::CH_SLASH, aet_pkg::CH_LPAREN, aet_pkg::CH_RPAREN: begin
          w_tok[w_cnt] = mk_tok(op_kind(char_byte), w_line, w_col, w_col);
          w_cnt = w_cnt + aet_pkg::COUNT_BITS'(1);
        end
        default: begin
          w_start = w_col;
          w_mode  = digit ? aet_pkg::MODE_INT : aet_pkg::MODE_ERR;
        end
      endcase
    end

    // column advance for every byte but a newline seen outside a token
    if (!taken && char_byte == aet_pkg::CH_NL) begin
      if (w_line != aet_pkg::LINE_MAX) begin
        w_line = w_line + aet_pkg::LINE_BITS'(1);
      end
      w_col = aet_pkg::COLUMN_BITS'(1);
      w_pin = 1'b0;
    end else begin
      at_max = (w_col == aet_pkg::COL_MAX);
      w_pin  = w_pin | at_max;
      if (!at_max) begin
        w_col = w_col + aet_pkg::COLUMN_BITS'(1);
      end
    end

    if (end_of_text) begin
      if (w_mode != aet_pkg::MODE_IDLE) begin
        w_tok[w_cnt] = mk_tok(pend_kind(w_mode), w_line, w_start, last_col(w_col, w_pin));
        w_cnt = w_cnt + aet_pkg::COUNT_BITS'(1);
      end
      w_tok[w_cnt] = mk_tok(aet_pkg::KIND_EOF, w_line, w_col, w_col);
      w_cnt   = w_cnt + aet_pkg::COUNT_BITS'(1);
      w_mode  = aet_pkg::MODE_IDLE;
      w_line  = aet_pkg::LINE_BITS'(1);
      w_col   = aet_pkg::COLUMN_BITS'(1);
      w_start = '0;
      w_pin   = 1'b0;
    end
  end

  // next state: hold unless a byte transfers
  always_comb begin
    mode_nxt  = mode_r;
    line_nxt  = line_r;
    col_nxt   = col_r;
    start_nxt = start_r;
    pin_nxt   = pin_r;
    if (accept) begin
      mode_nxt  = w_mode;
      line_nxt  = w_line;
      col_nxt   = w_col;
      start_nxt = w_start;
      pin_nxt   = w_pin;
    end
  end

  // outputs: drop bytes that give no token
  always_comb begin
    qwr.push       = accept && (w_cnt != '0);
    qwr.data.tok   = w_tok;
    qwr.data.count = w_cnt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= aet_pkg::MODE_IDLE;
      line_r  <= aet_pkg::LINE_BITS'(1);
      col_r   <= aet_pkg::COLUMN_BITS'(1);
      start_r <= '0;
      pin_r   <= 1'b0;
    end else begin
      mode_r  <= mode_nxt;
      line_r  <= line_nxt;
      col_r   <= col_nxt;
      start_r <= start_nxt;
      pin_r   <= pin_nxt;
    end
  end

endmodule

FILE: rtl/aet_queue.sv
module aet_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  aet_pkg::qwr_t    qwr,
  input  logic             pop,
  output logic             full,
  output logic             empty,
  output aet_pkg::bundle_t head
);

  aet_pkg::bundle_t                slot_r [aet_pkg::QUEUE_DEPTH];
  logic [aet_pkg::QPTR_BITS-1:0]   wptr_r, wptr_nxt;
  logic [aet_pkg::QPTR_BITS-1:0]   rptr_r, rptr_nxt;
  logic [aet_pkg::QCNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic                            do_push, do_pop;

  assign full    = (cnt_r == aet_pkg::QCNT_BITS'(aet_pkg::QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign head    = slot_r[rptr_r];
  assign do_push = qwr.push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == aet_pkg::QPTR_BITS'(aet_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : wptr_r + aet_pkg::QPTR_BITS'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == aet_pkg::QPTR_BITS'(aet_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : rptr_r + aet_pkg::QPTR_BITS'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + aet_pkg::QCNT_BITS'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - aet_pkg::QCNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= qwr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

FILE: rtl/aet_back.sv
module aet_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  aet_pkg::bundle_t             head,
  input  logic                         q_empty,
  output logic                         q_pop,
  input  logic                         out_pop,
  output logic                         out_empty,
  output logic [3:0]                   out_token_kind,
  output logic [aet_pkg::FIELD_BITS-1:0] out_token_line,
  output logic [aet_pkg::FIELD_BITS-1:0] out_first_column,
  output logic [aet_pkg::FIELD_BITS-1:0] out_final_column,
  output logic                         out_run_end
);

  logic [aet_pkg::COUNT_BITS-1:0] idx_r, idx_nxt;
  aet_pkg::token_t                cur;
  logic                           last;

  assign cur       = head.tok[idx_r];
  assign last      = (idx_r == head.count - aet_pkg::COUNT_BITS'(1));
  assign out_empty = q_empty;

  assign out_token_kind   = cur.kind;
  assign out_token_line   = cur.line;
  assign out_first_column = cur.first_col;
  assign out_final_column = cur.final_col;
  assign out_run_end      = last;

  // release the bundle after its last token transfers
  always_comb begin
    q_pop   = 1'b0;
    idx_nxt = idx_r;
    if (out_pop && !q_empty) begin
      if (last) begin
        q_pop   = 1'b1;
        idx_nxt = '0;
      end else begin
        idx_nxt = idx_r + aet_pkg::COUNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_BYTES = 95;

  typedef struct packed {
    aet_pkg::kind_t kind;
    logic [15:0]    line;
    logic [15:0]    first_col;
    logic [15:0]    final_col;
    logic           run_end;
  } tok_exp_t;

  typedef struct packed {
    logic [7:0]     ch;
    logic           eot;
    logic           given;
    aet_pkg::kind_t kind;
    logic [15:0]    line;
    logic [15:0]    first_col;
    logic [15:0]    final_col;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [7:0]  in_char_byte = 8'h00;
  logic        in_end_of_text = 1'b0;
  logic        out_pop = 1'b0;
  logic        out_empty;
  logic [3:0]  out_token_kind;
  logic [15:0] out_token_line;
  logic [15:0] out_first_column;
  logic [15:0] out_final_column;
  logic        out_run_end;

  arith_expr_tokenizer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_char_byte     (in_char_byte),
    .in_end_of_text   (in_end_of_text),
    .out_pop          (out_pop),
    .out_empty        (out_empty),
    .out_token_kind   (out_token_kind),
    .out_token_line   (out_token_line),
    .out_first_column (out_first_column),
    .out_final_column (out_final_column),
    .out_run_end      (out_run_end)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // lexer state mirrored for prediction
  aet_pkg::mode_t lx_mode;
  logic [15:0]    lx_line;
  logic [15:0]    lx_col;
  logic [15:0]    lx_start;
  bit             lx_pinned;

  tok_exp_t    step_toks[$];
  tok_exp_t    tokens_due[$];
  logic [7:0]  text_q[$];

  int          tx_idle_pct = 0;
  int          rx_stall_pct = 0;
  int          rx_hold_cycles = 0;
  int          mismatches = 0;
  int          tokens_seen = 0;
  int          bytes_sent = 0;
  int          cycles = 0;

  localparam logic [7:0] OP_CH [6] = '{aet_pkg::CH_PLUS, aet_pkg::CH_MINUS,
                                       aet_pkg::CH_STAR, aet_pkg::CH_SLASH,
                                       aet_pkg::CH_LPAREN, aet_pkg::CH_RPAREN};

  dir_row_t dir_rows [25] = '{
    '{aet_pkg::CH_PLUS,   1'b0, 1'b1, aet_pkg::KIND_PLUS,   16'd1, 16'd1, 16'd1},
    '{aet_pkg::CH_MINUS,  1'b0, 1'b1, aet_pkg::KIND_MINUS,  16'd1, 16'd2, 16'd2},
    '{aet_pkg::CH_STAR,   1'b0, 1'b1, aet_pkg::KIND_MUL,    16'd1, 16'd3, 16'd3},
    '{aet_pkg::CH_SLASH,  1'b0, 1'b1, aet_pkg::KIND_DIV,    16'd1, 16'd4, 16'd4},
    '{aet_pkg::CH_LPAREN, 1'b0, 1'b1, aet_pkg::KIND_LPAREN, 16'd1, 16'd5, 16'd5},
    '{aet_pkg::CH_RPAREN, 1'b0, 1'b1, aet_pkg::KIND_RPAREN, 16'd1, 16'd6, 16'd6},
    '{aet_pkg::CH_SPACE,  1'b0, 1'b0, aet_pkg::KIND_PLUS,   16'd0, 16'd0, 16'd0},
    '{aet_pkg::CH_ZERO,   1'b0, 1'b0, aet_pkg::KIND_PLUS,   16'd0, 16'd0, 16'd0},
    '{aet_pkg::CH_NINE,   1'b0, 1'b0, aet_pkg::KIND_PLUS,   16'd0, 16'd0, 16'd0},
    '{aet_pkg::CH_DOT,    1'b0, 1'b0, aet_pkg::KIND_PLUS,   16'd0, 16'd0, 16'd0},
    '{8'h35,              1'b0, 1'b0, aet_pkg::KIND_PLUS,   16'd0, 16'd0, 16'd0},
    // second dot closes the float and opens an error token
    '{aet_pkg::CH_DOT,    1'b0, 1'b0, aet_pkg::KIND_PLUS,   16'd0, 16'd0, 16'd0},
    '{aet_pkg::CH_NL,     1'b0, 1'b0, aet_pkg::KIND_PLUS,   16'd0, 16'd0, 16'd0},
    '{8'hFF,              1'b0, 1'b0, aet_pkg::KIND_PLUS,   16'd0, 16'd0, 16'd0},
    '{8'h00,              1'b1, 1'b0, aet_pkg::KIND_PLUS,   16'd0, 16'd0, 16'd0},
    '{aet_pkg::CH_NL,     1'b0, 1'b1, aet_pkg::KIND_EOL,    16'd1, 16'd1, 16'd1},
    '{8'h37,              1'b0, 1'b0, aet_pkg::KIND_PLUS,   16'd0, 16'd0, 16'd0},
    '{aet_pkg::CH_NL,     1'b0, 1'b0, aet_pkg::KIND_PLUS,   16'd0, 16'd0, 16'd0},
    '{8'h33,              1'b1, 1'b0, aet_pkg::KIND_PLUS,   16'd0, 16'd0, 16'd0},
    '{aet_pkg::CH_SPACE,  1'b1, 1'b1, aet_pkg::KIND_EOF,    16'd1, 16'd2, 16'd2},
    '{8'h80,              1'b0, 1'b0, aet_pkg::KIND_PLUS,   16'd0, 16'd0, 16'd0},
    '{aet_pkg::CH_PLUS,   1'b1, 1'b0, aet_pkg::KIND_PLUS,   16'd0, 16'd0, 16'd0},
    '{8'h35,              1'b0, 1'b0, aet_pkg::KIND_PLUS,   16'd0, 16'd0, 16'd0},
    '{aet_pkg::CH_DOT,    1'b1, 1'b0, aet_pkg::KIND_PLUS,   16'd0, 16'd0, 16'd0},
    '{aet_pkg::CH_NL,     1'b1, 1'b0, aet_pkg::KIND_PLUS,   16'd0, 16'd0, 16'd0}
  };

  function automatic void lx_reset();
    lx_mode   = aet_pkg::MODE_IDLE;
    lx_line   = 16'd1;
    lx_col    = 16'd1;
    lx_start  = 16'd0;
    lx_pinned = 1'b0;
  endfunction

  function automatic void stage_tok(input tok_exp_t t);
    step_toks = {step_toks, t};
  endfunction

  function automatic void due_tok(input tok_exp_t t);
    tokens_due = {tokens_due, t};
  endfunction

  function automatic void add_text_byte(input logic [7:0] c);
    text_q = {text_q, c};
  endfunction

  // columns stop at the top; the byte taken there pins the column
  function automatic void col_step();
    if (lx_col == aet_pkg::COL_MAX) lx_pinned = 1'b1;
    else lx_col = lx_col + 16'd1;
  endfunction

  function automatic void flush_pending();
    aet_pkg::kind_t k;
    logic [15:0]    fin;
    k = (lx_mode == aet_pkg::MODE_INT) ? aet_pkg::KIND_INT :
        (lx_mode == aet_pkg::MODE_FLOAT) ? aet_pkg::KIND_FLOAT : aet_pkg::KIND_ERR;
    if (lx_pinned) fin = aet_pkg::COL_MAX;
    else fin = (lx_col > 16'd1) ? lx_col - 16'd1 : 16'd1;
    stage_tok('{k, lx_line, lx_start, fin, 1'b0});
    lx_mode = aet_pkg::MODE_IDLE;
  endfunction

  function automatic void op_token(input aet_pkg::kind_t k);
    stage_tok('{k, lx_line, lx_col, lx_col, 1'b0});
    col_step();
  endfunction

  // tokens caused by one transferred byte, in order
  function automatic void lex_predict(input logic [7:0] c, input logic eot);
    bit digit;
    bit taken;
    step_toks = {};
    digit = (c >= aet_pkg::CH_ZERO) && (c <= aet_pkg::CH_NINE);
    taken = 1'b0;
    case (lx_mode)
      aet_pkg::MODE_INT: begin
        if (digit) begin
          col_step();
          taken = 1'b1;
        end else if (c == aet_pkg::CH_DOT) begin
          lx_mode = aet_pkg::MODE_FLOAT;
          col_step();
          taken = 1'b1;
        end else begin
          flush_pending();
        end
      end
      aet_pkg::MODE_FLOAT: begin
        if (digit) begin
          col_step();
          taken = 1'b1;
        end else begin
          flush_pending();
        end
      end
      aet_pkg::MODE_ERR: begin
        col_step();
        taken = 1'b1;
      end
      default: ;
    endcase
    if (!taken) begin
      case (c)
        aet_pkg::CH_SPACE: col_step();
        aet_pkg::CH_NL: begin
          stage_tok('{aet_pkg::KIND_EOL, lx_line, lx_col, lx_col, 1'b0});
          if (lx_line != aet_pkg::LINE_MAX) lx_line = lx_line + 16'd1;
          lx_col    = 16'd1;
          lx_pinned = 1'b0;
        end
        aet_pkg::CH_PLUS:   op_token(aet_pkg::KIND_PLUS);
        aet_pkg::CH_MINUS:  op_token(aet_pkg::KIND_MINUS);
        aet_pkg::CH_STAR:   op_token(aet_pkg::KIND_MUL);
        aet_pkg::CH_SLASH:  op_token(aet_pkg::KIND_DIV);
        aet_pkg::CH_LPAREN: op_token(aet_pkg::KIND_LPAREN);
        aet_pkg::CH_RPAREN: op_token(aet_pkg::KIND_RPAREN);
        default: begin
          lx_start = lx_col;
          lx_mode  = digit ? aet_pkg::MODE_INT : aet_pkg::MODE_ERR;
          col_step();
        end
      endcase
    end
    if (eot) begin
      if (lx_mode != aet_pkg::MODE_IDLE) flush_pending();
      stage_tok('{aet_pkg::KIND_EOF, lx_line, lx_col, lx_col, 1'b0});
      lx_reset();
    end
    if (step_toks.size() > 0) step_toks[step_toks.size() - 1].run_end = 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= 30)
      $display("tb: mismatch on token %0d: %s got %0d want %0d", tokens_seen, what, got, want);
  endtask

  // offer one byte, hold it until it transfers, then maybe idle
  task automatic send_byte(input logic [7:0] c, input logic eot, input logic given,
                           input tok_exp_t given_tok);
    in_push        <= 1'b1;
    in_char_byte   <= c;
    in_end_of_text <= eot;
    do @(posedge clk); while (in_full);
    lex_predict(c, eot);
    if (given) due_tok(given_tok);
    else foreach (step_toks[i]) due_tok(step_toks[i]);
    bytes_sent++;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
  endtask

  // mostly well-formed expressions; some pure noise, some left open
  task automatic send_text();
    int  n_lex;
    int  r;
    int  nd;
    bit  noise;
    bit  close;
    logic eot;
    text_q = {};
    noise = ($urandom_range(9) == 0);
    close = ($urandom_range(9) != 0);
    n_lex = $urandom_range(3, 12);
    for (int i = 0; i < n_lex; i++) begin
      r = $urandom_range(99);
      if (noise || r >= 92) begin
        add_text_byte(8'($urandom_range(255)));
      end else if (r < 30) begin
        nd = $urandom_range(1, 4);
        for (int j = 0; j < nd; j++)
          add_text_byte(8'(aet_pkg::CH_ZERO + $urandom_range(9)));
        if ($urandom_range(9) < 4) begin
          add_text_byte(aet_pkg::CH_DOT);
          nd = $urandom_range(0, 3);
          for (int j = 0; j < nd; j++)
            add_text_byte(8'(aet_pkg::CH_ZERO + $urandom_range(9)));
          if ($urandom_range(9) == 0) add_text_byte(aet_pkg::CH_DOT);
        end
      end else if (r < 55) begin
        add_text_byte(OP_CH[$urandom_range(5)]);
      end else if (r < 70) begin
        nd = $urandom_range(1, 3);
        for (int j = 0; j < nd; j++) add_text_byte(aet_pkg::CH_SPACE);
      end else if (r < 82) begin
        add_text_byte(aet_pkg::CH_NL);
      end else begin
        add_text_byte(8'($urandom_range(8'h21, 8'h7E)));
      end
    end
    foreach (text_q[k]) begin
      eot = (k == text_q.size() - 1) ? close : (noise && $urandom_range(7) == 0);
      send_byte(text_q[k], eot, 1'b0, '0);
    end
  endtask

  // stop offering and wait for every due token
  task automatic drain();
    in_push <= 1'b0;
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  always @(posedge clk) begin : rx_side
    tok_exp_t want;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (tokens_due.size() == 0) begin
          report_mismatch("token with none due, kind", out_token_kind, -1);
        end else begin
          want = tokens_due.pop_front();
          if (out_token_kind != want.kind) report_mismatch("kind", out_token_kind, want.kind);
          if (out_token_line != want.line) report_mismatch("line", out_token_line, want.line);
          if (out_first_column != want.first_col)
            report_mismatch("first column", out_first_column, want.first_col);
          if (out_final_column != want.final_col)
            report_mismatch("final column", out_final_column, want.final_col);
          if (out_run_end != want.run_end)
            report_mismatch("run end", out_run_end, want.run_end);
        end
        tokens_seen++;
      end
      if (rx_hold_cycles > 0) begin
        rx_hold_cycles--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int phase_start;
    lx_reset();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      send_byte(dir_rows[i].ch, dir_rows[i].eot, dir_rows[i].given,
                '{dir_rows[i].kind, dir_rows[i].line, dir_rows[i].first_col,
                  dir_rows[i].final_col, 1'b1});
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      tx_idle_pct  = (ph == 1) ? 60 : (ph == 3) ? 23 : 0;
      rx_stall_pct = (ph == 2) ? 60 : (ph == 3) ? 23 : 0;
      // long reader hold-off while bytes keep coming, to fill the block
      if (ph == 0) rx_hold_cycles = 300;
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) send_text();
      drain();
    end

    rx_stall_pct = 0;
    repeat (20) @(posedge clk);
    $display("tb: %0d bytes sent, %0d tokens checked, %0d mismatches", bytes_sent,
             tokens_seen, mismatches);
    $display("tb: covered operators, int/float/error tokens, eol/eof, stalls on both sides");
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
